>>> rtl/core/utc_pkg.sv
package utc_pkg;

  // Number of byte slots in one queued job (one input byte yields at most four results)
  localparam int SLOTS = 4;

  // Default number of jobs between the front and back halves
  localparam int QUEUE_DEPTH = 4;

  // Marker byte for anything that cannot be decoded
  localparam logic [7:0] BYTE_UNKNOWN = 8'h3F;

  // One transaction's worth of results, in scan order
  typedef struct packed {
    logic [SLOTS-1:0][7:0] val;   // candidate byte per scan position
    logic [SLOTS-1:0]      keep;  // position produces a result
    logic                  fin;   // caused by the final byte of the text
  } job_t;

endpackage

>>> rtl/core/utc_front.sv
module utc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          text_last,
  input  logic          full,
  output logic          push,
  output utc_pkg::job_t job
);

  // Standard positions for U+0400..040F and U+0450..045F, zero where unmapped
  localparam logic [7:0] UPPER_ROW [16] = '{
    8'h00, 8'hA8, 8'h80, 8'h81, 8'hAA, 8'hBD, 8'hB2, 8'hAF,
    8'hA3, 8'h8A, 8'h8C, 8'h8E, 8'h8D, 8'h00, 8'hA1, 8'h8F
  };
  localparam logic [7:0] LOWER_ROW [16] = '{
    8'h00, 8'hB8, 8'h90, 8'h83, 8'hBA, 8'hBE, 8'hB3, 8'hBF,
    8'hBC, 8'h9A, 8'h9C, 8'h9E, 8'h9D, 8'h00, 8'hA2, 8'h9F
  };
  localparam logic [10:0] CP_CYR_FIRST = 11'h410;
  localparam logic [10:0] CP_CYR_LAST  = 11'h44F;
  localparam logic [6:0]  CP_UPPER_HI  = 7'h40;
  localparam logic [6:0]  CP_LOWER_HI  = 7'h45;
  localparam logic [10:0] CP_GHE_UP    = 11'h490;
  localparam logic [10:0] CP_GHE_LO    = 11'h491;
  localparam logic [10:0] CP_QUOTE_L   = 11'h0AB;
  localparam logic [10:0] CP_QUOTE_R   = 11'h0BB;

  // Sequence length announced by a byte: 1 for ASCII, 2..4 for leads, 0 for anything else
  function automatic logic [2:0] byte_need(input logic [7:0] b);
    logic [2:0] r;
    priority if (b[7] == 1'b0)         r = 3'd1;
    else if (b[7:5] == 3'b110)         r = 3'd2;
    else if (b[7:4] == 4'b1110)        r = 3'd3;
    else if (b[7:3] == 5'b11110)       r = 3'd4;
    else                               r = 3'd0;
    return r;
  endfunction

  // Single-byte form of a two-byte sequence, zero when it has none
  function automatic logic [7:0] map_pair(input logic [7:0] lead, input logic [7:0] cont);
    logic [10:0] cp;
    logic [7:0]  r;
    cp = {lead[4:0], cont[5:0]};
    priority if (cp >= CP_CYR_FIRST && cp <= CP_CYR_LAST)
                                   r = {2'b11, 6'(cp - CP_CYR_FIRST)};
    else if (cp[10:4] == CP_UPPER_HI) r = UPPER_ROW[cp[3:0]];
    else if (cp[10:4] == CP_LOWER_HI) r = LOWER_ROW[cp[3:0]];
    else if (cp == CP_GHE_UP)         r = 8'hA5;
    else if (cp == CP_GHE_LO)         r = 8'hB4;
    else if (cp == CP_QUOTE_L)        r = 8'hAB;
    else if (cp == CP_QUOTE_R)        r = 8'hBB;
    else                              r = 8'h00;
    return r;
  endfunction

  // Bytes of an unsettled sequence; held[0] is always its lead
  logic [2:0][7:0] held;
  logic [1:0]      held_count;
  logic [2:0][7:0] held_next;
  logic [1:0]      held_count_next;

  logic                              accept;
  logic [utc_pkg::SLOTS-1:0][7:0]    scan_buf;
  logic [utc_pkg::SLOTS-1:0][7:0]    val;
  logic [utc_pkg::SLOTS-1:0]         keep;
  logic [2:0]                        n;
  logic [2:0]                        pos;
  logic [2:0]                        need;
  logic [1:0]                        rem;
  logic                              stop;
  logic [7:0]                        cur_b;
  logic [7:0]                        nxt_b;
  logic [7:0]                        mapped;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // Held bytes followed by the new byte
  always_comb begin
    unique case (held_count)
      2'd0:    scan_buf = {8'h00, 8'h00, 8'h00, in_byte};
      2'd1:    scan_buf = {8'h00, 8'h00, in_byte, held[0]};
      2'd2:    scan_buf = {8'h00, in_byte, held[1], held[0]};
      default: scan_buf = {in_byte, held[2], held[1], held[0]};
    endcase
    n = {1'b0, held_count} + 3'd1;
  end

  // Scan: each step settles one sequence or, unless the text ends, stops at an incomplete lead
  always_comb begin
    val    = scan_buf;
    keep   = '0;
    pos    = 3'd0;
    stop   = 1'b0;
    cur_b  = 8'h00;
    nxt_b  = 8'h00;
    need   = 3'd0;
    mapped = 8'h00;
    for (int s = 0; s < utc_pkg::SLOTS; s++) begin
      if (!stop && pos < n) begin
        cur_b = scan_buf[pos[1:0]];
        nxt_b = scan_buf[pos[1:0] + 2'd1];
        need  = byte_need(cur_b);
        if (need == 3'd1) begin
          keep[pos[1:0]] = 1'b1;
          pos = pos + 3'd1;
        end else if (need == 3'd0) begin
          val[pos[1:0]]  = utc_pkg::BYTE_UNKNOWN;
          keep[pos[1:0]] = 1'b1;
          pos = pos + 3'd1;
        end else if (({1'b0, pos} + {1'b0, need}) > {1'b0, n}) begin
          // Cut short: wait for more bytes, or give up at end of text
          if (text_last) begin
            val[pos[1:0]]  = utc_pkg::BYTE_UNKNOWN;
            keep[pos[1:0]] = 1'b1;
            pos = pos + 3'd1;
          end else begin
            stop = 1'b1;
          end
        end else if (need == 3'd2) begin
          if (nxt_b[7:6] == 2'b10) begin
            mapped = map_pair(cur_b, nxt_b);
            keep[pos[1:0]] = 1'b1;
            if (mapped != 8'h00) begin
              val[pos[1:0]] = mapped;
            end else begin
              keep[pos[1:0] + 2'd1] = 1'b1;
            end
            pos = pos + 3'd2;
          end else begin
            val[pos[1:0]]  = utc_pkg::BYTE_UNKNOWN;
            keep[pos[1:0]] = 1'b1;
            pos = pos + 3'd1;
          end
        end else begin
          // Three- and four-byte sequences pass through unchecked
          for (int p = 0; p < utc_pkg::SLOTS; p++) begin
            if (3'(p) >= pos && ({1'b0, 3'(p)} < ({1'b0, pos} + {1'b0, need}))) begin
              keep[p] = 1'b1;
            end
          end
          pos = pos + need;
        end
      end
    end
  end

  // Whatever the scan left unsettled is held for the next transaction (at most three bytes)
  always_comb begin
    rem = 2'(n - pos);
    for (int k = 0; k < 3; k++) begin
      held_next[k] = scan_buf[pos[1:0] + 2'(k)];
    end
    held_count_next = text_last ? 2'd0 : rem;
  end

  assign push     = accept && (keep != '0);
  assign job.val  = val;
  assign job.keep = keep;
  assign job.fin  = text_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

  // Held data always opens with a multi-byte lead
  a_held_lead: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd0 |-> (held[0][7:6] == 2'b11 && held[0][7:3] != 5'b11111))
    else $error("held bytes do not start with a lead");

  // End of text flushes everything
  a_fin_flush: assert property (@(posedge clk) disable iff (rst)
    accept && text_last |=> held_count == 2'd0)
    else $error("bytes still held after end of text");

endmodule

>>> rtl/core/utc_queue.sv
module utc_queue #(
  parameter int DEPTH = utc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  utc_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output utc_pkg::job_t rd_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  utc_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = entries[head];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + PTR_W'(1);
      end
      if (pop) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= wr_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count < CNT_W'(DEPTH))
    else $error("job written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("job taken from an empty queue");

endmodule

>>> rtl/core/utc_back.sv
module utc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  utc_pkg::job_t q_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          run_end,
  output logic          text_end
);

  // Job being emitted; keep holds the positions not yet delivered
  logic                         cur_valid;
  utc_pkg::job_t                cur;
  logic [1:0]                   sel;
  logic [utc_pkg::SLOTS-1:0]    rest;
  logic                         last;
  logic                         take;
  logic                         load;

  // Lowest pending position goes out next
  always_comb begin
    priority if (cur.keep[0]) sel = 2'd0;
    else if (cur.keep[1])     sel = 2'd1;
    else if (cur.keep[2])     sel = 2'd2;
    else                      sel = 2'd3;
    rest = cur.keep;
    rest[sel] = 1'b0;
    last = (rest == '0);
  end

  assign out_valid = cur_valid;
  assign out_byte  = cur.val[sel];
  assign run_end   = last;
  assign text_end  = last && cur.fin;

  assign take = cur_valid && !out_stall;
  assign load = !cur_valid || (take && last);
  assign pop  = load && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      cur_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end else if (take) begin
      cur.keep <= rest;
    end
  end

  a_pending: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur.keep != '0)
    else $error("output valid with no pending byte");

endmodule

>>> rtl/core/utf8_to_cp1251_transcoder_unit.sv
// Path: a result is written into the job queue by the transaction that settles its
//   sequence (front scan and queue write), then presented from the emitter register.
// Throughput: one input byte per cycle while the queue is not full; one output byte per
//   cycle unless out_stall; the queue absorbs input while a job's results are sent.
// Reset (rst, synchronous): held bytes, job queue and emitter are emptied.
module utf8_to_cp1251_transcoder_unit #(
  parameter int QUEUE_DEPTH = utc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       text_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       text_end
);

  logic          push;
  logic          full;
  logic          pop;
  logic          q_valid;
  utc_pkg::job_t wr_job;
  utc_pkg::job_t q_job;

  // Scan and classify incoming bytes
  utc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .text_last (text_last),
    .full      (full),
    .push      (push),
    .job       (wr_job)
  );

  // Decouple scanning from emission
  utc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (wr_job),
    .full     (full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  // Emit one byte per transaction
  utc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_end   (run_end),
    .text_end  (text_end)
  );

endmodule
